### design/ptt_pkg.sv
// Package for the periodic timer table.
// Types, sizes and codes imported by the top level, front end, back end and divider; no dependencies.
package ptt_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
    localparam int QDEPTH     = 2;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_REM  = 2'd1,
        OP_FIRE = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_ZERO = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_APPLY,
        S_MIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op          op;
        logic [15:0]  timer_id;
        logic [63:0]  start_time;
        logic [31:0]  interval;
        logic [63:0]  time_now;
    } t_item;

endpackage

### design/ptt_in_if.sv
// Input channel interface of the periodic timer table.
// Carries valid, ready and one command; no dependencies.
interface ptt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] timer_id;
    logic [63:0] start_time;
    logic [31:0] interval;
    logic [63:0] time_now;

    modport source (output valid, mode, timer_id, start_time, interval, time_now,
                    input ready);
    modport sink   (input valid, mode, timer_id, start_time, interval, time_now,
                    output ready);
endinterface

### design/ptt_out_if.sv
// Result channel interface of the periodic timer table.
// Carries valid, ready and one result; no dependencies.
interface ptt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        fired;
    logic [15:0] fired_id;
    logic [63:0] elapsed;
    logic [63:0] next_fire_time;
    logic [4:0]  timer_count;
    logic        last;

    modport source (output valid, status, fired, fired_id, elapsed, next_fire_time,
                    timer_count, last, input ready);
    modport sink   (input valid, status, fired, fired_id, elapsed, next_fire_time,
                    timer_count, last, output ready);
endinterface

### design/periodic_timer_table.sv
// Periodic timer table, top level. Add/remove: an id scan, the table update, a minimum pass
// and the result. Fire: a scan with a bit-serial remainder division per due timer,
// then a minimum pass, then one result per cycle while the result channel is ready.
// One command is in the back end at a time; a 2-entry queue takes the next.
// Synchronous active-low reset empties the table; entries need no clearing pass.
module periodic_timer_table
    import ptt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptt_in_if.sink    i_in,
    ptt_out_if.source o_out
);
    logic  q_valid, q_ready;
    t_item q_item;

    ptt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_ready (q_ready)
    );

    ptt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_ready (q_ready),
        .o_out     (o_out)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.timer_count <= 5'(MAX_TIMERS))
        else $error("timer count out of range");

    a_fired_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.fired |-> o_out.status == ST_OK)
        else $error("fired result with bad status");

    a_empty_never: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.timer_count == 5'd0 |-> o_out.next_fire_time == '1)
        else $error("empty table reports a fire time");
endmodule

### design/ptt_front.sv
// Front end: accepts commands, decodes the mode and queues them.
// Depends on ptt_pkg and ptt_in_if.
module ptt_front
    import ptt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    ptt_in_if.sink i_in,
    output logic   o_q_valid,
    output t_item  o_q_item,
    input  logic   i_q_ready
);
    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_item           r_q [QDEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    t_item           n_item;
    logic            push, pop;

    always_comb begin
        n_item.op         = t_op'(i_in.mode);
        n_item.timer_id   = i_in.timer_id;
        n_item.start_time = i_in.start_time;
        n_item.interval   = i_in.interval;
        n_item.time_now   = i_in.time_now;
    end

    assign i_in.ready = (r_cnt != CW'(QDEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = o_q_valid && i_q_ready;
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(push) - CW'(pop);
        end
    end
endmodule

### design/ptt_div.sv
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, remainder only.
// One quotient bit per cycle; depends on ptt_pkg.
module ptt_div
    import ptt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dvd,
    input  logic [31:0] i_dvs,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [63:0] r_dvd;
    logic [31:0] r_dvs;
    logic [31:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] sh;
    logic [32:0] diff;

    assign sh     = {r_rem, r_dvd[63]};
    assign diff   = sh - {1'b0, r_dvs};
    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_dvs <= i_dvs;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= diff[32] ? sh[31:0] : diff[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### design/ptt_back.sv
// Back end: timer table, command sequencer and result emission.
// Depends on ptt_pkg, ptt_out_if and ptt_div.
module ptt_back
    import ptt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_item     i_q_item,
    output logic      o_q_ready,
    ptt_out_if.source o_out
);
    logic [15:0]      r_id [MAX_TIMERS];
    logic [63:0]      r_st [MAX_TIMERS];
    logic [31:0]      r_iv [MAX_TIMERS];
    logic [63:0]      r_nx [MAX_TIMERS];
    logic [15:0]      r_fid [MAX_TIMERS];
    logic [63:0]      r_fel [MAX_TIMERS];

    t_state           r_state, n_state;
    t_item            r_cur;
    t_status          r_status;
    logic [CNT_W-1:0] r_count, r_i, r_nf, r_k;
    logic [IDX_W-1:0] r_slot;
    logic             r_hit;
    logic [63:0]      r_min;

    logic [IDX_W-1:0] ix;
    logic             more, due, div_start, div_done, is_last, any_fired;
    logic [31:0]      div_rem;

    assign ix        = r_i[IDX_W-1:0];
    assign more      = (r_i < r_count);
    assign due       = (r_cur.time_now > r_nx[ix]);
    assign div_start = (r_state == S_SCAN) && more && (r_cur.op == OP_FIRE) && due;
    assign any_fired = (r_cur.op == OP_FIRE) && (r_nf != '0);
    assign is_last   = !any_fired || (r_k == r_nf - 1'b1);

    ptt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (r_nx[ix] - r_st[ix]),
        .i_dvs   (r_iv[ix]),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    assign o_q_ready            = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_EMIT);
    assign o_out.status         = r_status;
    assign o_out.fired          = any_fired;
    assign o_out.fired_id       = any_fired ? r_fid[r_k[IDX_W-1:0]] : '0;
    assign o_out.elapsed        = any_fired ? r_fel[r_k[IDX_W-1:0]] : '0;
    assign o_out.next_fire_time = r_min;
    assign o_out.timer_count    = 5'(r_count);
    assign o_out.last           = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_q_valid) n_state = S_SCAN;
            S_SCAN: begin
                if (!more) begin
                    n_state = S_APPLY;
                end else if (div_start) begin
                    n_state = S_DIV;
                end
            end
            S_DIV:   if (div_done) n_state = S_SCAN;
            S_APPLY: n_state = S_MIN;
            S_MIN:   if (!more) n_state = S_EMIT;
            S_EMIT:  if (o_out.ready && is_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // table and sequencer datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cur    <= i_q_item;
                r_i      <= '0;
                r_hit    <= 1'b0;
                r_nf     <= '0;
                r_status <= ST_OK;
            end
            S_SCAN: begin
                if (more && !div_start) begin
                    if (r_cur.op != OP_FIRE && !r_hit && r_id[ix] == r_cur.timer_id) begin
                        r_hit  <= 1'b1;
                        r_slot <= ix;
                    end
                    r_i <= r_i + 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    r_nx[ix]                <= r_nx[ix] - 64'(div_rem) + 64'(r_iv[ix]);
                    r_fid[r_nf[IDX_W-1:0]]  <= r_id[ix];
                    r_fel[r_nf[IDX_W-1:0]]  <= r_cur.time_now - r_st[ix];
                    r_nf                    <= r_nf + 1'b1;
                    r_i                     <= r_i + 1'b1;
                end
            end
            S_APPLY: begin
                r_i   <= '0;
                r_min <= '1;
                if (r_cur.op == OP_ADD) begin
                    priority if (r_hit) begin
                        r_status <= ST_DUP;
                    end else if (r_count == CNT_W'(MAX_TIMERS)) begin
                        r_status <= ST_FULL;
                    end else if (r_cur.interval == '0) begin
                        r_status <= ST_ZERO;
                    end else begin
                        r_id[r_count[IDX_W-1:0]] <= r_cur.timer_id;
                        r_st[r_count[IDX_W-1:0]] <= r_cur.start_time;
                        r_iv[r_count[IDX_W-1:0]] <= r_cur.interval;
                        r_nx[r_count[IDX_W-1:0]] <= r_cur.start_time;
                    end
                end else if (r_cur.op == OP_REM) begin
                    if (!r_hit) begin
                        r_status <= ST_DUP;
                    end else begin
                        for (int j = 0; j < MAX_TIMERS - 1; j++) begin
                            if (IDX_W'(j) >= r_slot) begin
                                r_id[j] <= r_id[j+1];
                                r_st[j] <= r_st[j+1];
                                r_iv[j] <= r_iv[j+1];
                                r_nx[j] <= r_nx[j+1];
                            end
                        end
                    end
                end
            end
            S_MIN: begin
                if (more) begin
                    if (r_nx[ix] < r_min) begin
                        r_min <= r_nx[ix];
                    end
                    r_i <= r_i + 1'b1;
                end
                r_k <= '0;
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == S_APPLY) begin
            if (r_cur.op == OP_ADD && !r_hit && r_count != CNT_W'(MAX_TIMERS)
                    && r_cur.interval != '0) begin
                r_count <= r_count + 1'b1;
            end else if (r_cur.op == OP_REM && r_hit) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

### tb/tb_board.sv
// Scoreboard for the periodic timer table testbench.
// Holds a predictor of the timer table and the queue of expected results.
// Depends on ptt_pkg.
class timer_board;
    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [15:0] fired_id;
        logic [63:0] elapsed;
        logic [63:0] next_fire_time;
        logic [4:0]  timer_count;
        logic        last;
    } t_res;

    logic [15:0] tid[ptt_pkg::MAX_TIMERS];
    logic [63:0] tstart[ptt_pkg::MAX_TIMERS];
    logic [31:0] tivl[ptt_pkg::MAX_TIMERS];
    logic [63:0] tnext[ptt_pkg::MAX_TIMERS];
    int          ntimers;
    t_res        pending[$];
    int          mismatches;
    int          results_seen;
    int          fires_seen;

    function int find_id(logic [15:0] id);
        for (int i = 0; i < ntimers; i++) if (tid[i] == id) return i;
        return -1;
    endfunction

    function void note_item(ptt_pkg::t_op op, logic [15:0] id, logic [63:0] st,
                            logic [31:0] iv, logic [63:0] now);
        t_res        batch[$];
        t_res        r;
        int          s;
        logic [63:0] nf;
        logic [63:0] base;
        r = '0;
        case (op)
            ptt_pkg::OP_ADD: begin
                if (find_id(id) >= 0) r.status = ptt_pkg::ST_DUP;
                else if (ntimers >= ptt_pkg::MAX_TIMERS) r.status = ptt_pkg::ST_FULL;
                else if (iv == 0) r.status = ptt_pkg::ST_ZERO;
                else begin
                    tid[ntimers] = id; tstart[ntimers] = st;
                    tivl[ntimers] = iv; tnext[ntimers] = st;
                    ntimers++;
                end
                batch = {batch, r};
            end
            ptt_pkg::OP_REM: begin
                s = find_id(id);
                if (s < 0) r.status = ptt_pkg::ST_DUP;
                else begin
                    for (int i = s; i + 1 < ntimers; i++) begin
                        tid[i] = tid[i+1]; tstart[i] = tstart[i+1];
                        tivl[i] = tivl[i+1]; tnext[i] = tnext[i+1];
                    end
                    ntimers--;
                end
                batch = {batch, r};
            end
            ptt_pkg::OP_FIRE: begin
                for (int i = 0; i < ntimers; i++) begin
                    if (now > tnext[i]) begin
                        base = (tnext[i] - tstart[i]) / {32'd0, tivl[i]} + 64'd1;
                        tnext[i] = tstart[i] + base * {32'd0, tivl[i]};
                        r = '0;
                        r.fired = 1'b1;
                        r.fired_id = tid[i];
                        r.elapsed = now - tstart[i];
                        batch = {batch, r};
                    end
                end
                if (batch.size() == 0) begin
                    r = '0;
                    batch = {batch, r};
                end
            end
            default: batch = {batch, r};
        endcase
        nf = '1;
        for (int i = 0; i < ntimers; i++) if (tnext[i] < nf) nf = tnext[i];
        foreach (batch[k]) begin
            batch[k].next_fire_time = nf;
            batch[k].timer_count = 5'(ntimers);
            batch[k].last = (k == batch.size() - 1);
            pending = {pending, batch[k]};
        end
    endfunction

    function void check_result(logic [1:0] status, logic fired, logic [15:0] fired_id,
                               logic [63:0] elapsed, logic [63:0] next_fire_time,
                               logic [4:0] timer_count, logic last);
        t_res got;
        t_res e;
        got.status = status; got.fired = fired; got.fired_id = fired_id;
        got.elapsed = elapsed; got.next_fire_time = next_fire_time;
        got.timer_count = timer_count; got.last = last;
        results_seen++;
        if (got.fired) fires_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction");
            return;
        end
        e = pending.pop_front();
        if (got !== e) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp st=%0d f=%0d id=%h el=%h nf=%h cnt=%0d l=%0d",
                         e.status, e.fired, e.fired_id, e.elapsed, e.next_fire_time,
                         e.timer_count, e.last);
                $display("          got st=%0d f=%0d id=%h el=%h nf=%h cnt=%0d l=%0d",
                         got.status, got.fired, got.fired_id, got.elapsed,
                         got.next_fire_time, got.timer_count, got.last);
            end
        end
    endfunction
endclass

### tb/tb.sv
// Top-level testbench of the periodic timer table: directed and random commands,
// random gaps on both channels, results checked by timer_board.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if and tb_board.sv.
module tb;
    import ptt_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    ptt_in_if    cmd_if();
    ptt_out_if   res_if();
    timer_board  board;
    int          cycles = 0;
    bit          stim_done;
    logic [15:0] used_ids[$];
    logic [63:0] clock_now;

    periodic_timer_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if.sink),
        .o_out   (res_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_cmd(t_op op, logic [15:0] id, logic [63:0] st,
                            logic [31:0] iv, logic [63:0] now);
        int g;
        cmd_if.valid      <= 1'b1;
        cmd_if.mode       <= op;
        cmd_if.timer_id   <= id;
        cmd_if.start_time <= st;
        cmd_if.interval   <= iv;
        cmd_if.time_now   <= now;
        do @(posedge i_clk); while (!cmd_if.ready);
        board.note_item(op, id, st, iv, now);
        @(negedge i_clk);
        g = gap_len();
        if (g != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [15:0] pick_id();
        if (used_ids.size() != 0 && $urandom_range(0, 3) != 0)
            return used_ids[$urandom_range(0, used_ids.size() - 1)];
        return 16'($urandom());
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_result(res_if.status, res_if.fired, res_if.fired_id,
                               res_if.elapsed, res_if.next_fire_time,
                               res_if.timer_count, res_if.last);
        end
    end

    initial begin
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stim_done && $urandom_range(0, 3) == 0) res_if.ready <= 1'b1;
            else res_if.ready <= (gap_len() == 0) || ($urandom_range(0, 1) == 0);
        end
    end

    initial begin
        int          k;
        int          p;
        logic [15:0] id;
        board = new();
        stim_done = 0;
        cmd_if.valid = 1'b0; cmd_if.mode = OP_NOP; cmd_if.timer_id = '0;
        cmd_if.start_time = '0; cmd_if.interval = '0; cmd_if.time_now = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // directed
        send_cmd(OP_FIRE, 16'h0, 64'd0, 32'd0, '1);
        send_cmd(OP_REM, 16'h1234, 64'd0, 32'd0, 64'd0);
        send_cmd(OP_ADD, 16'h0000, 64'd0, 32'd0, 64'd0);
        send_cmd(OP_ADD, 16'h0000, 64'd0, 32'hFFFFFFFF, 64'd0);
        send_cmd(OP_ADD, 16'h0000, 64'd5, 32'd1, 64'd0);
        send_cmd(OP_ADD, 16'hFFFF, '1, 32'd1, 64'd0);
        send_cmd(OP_ADD, 16'h0101, 64'hFFFFFFFFFFFFFFF0, 32'hFFFFFFFF, 64'd0);
        send_cmd(OP_ADD, 16'h0202, 64'd100, 32'd7, 64'd0);
        send_cmd(OP_FIRE, 16'h0, 64'd0, 32'd0, 64'd0);
        send_cmd(OP_FIRE, 16'h0, 64'd0, 32'd0, '1);
        send_cmd(OP_FIRE, 16'h0, 64'd0, 32'd0, '1);
        send_cmd(OP_NOP, 16'hFFFF, '1, '1, '1);
        for (int i = 0; i < 13; i++) send_cmd(OP_ADD, 16'h0300 + 16'(i), 64'(i), 32'd3, 0);
        send_cmd(OP_ADD, 16'hAAAA, 64'd1, 32'd0, 64'd0);
        send_cmd(OP_REM, 16'h0202, 64'd0, 32'd0, 64'd0);
        send_cmd(OP_REM, 16'h0300, 64'd0, 32'd0, 64'd0);
        send_cmd(OP_FIRE, 16'h0, 64'd0, 32'd0, 64'd200);
        // drain everything
        cmd_if.valid <= 1'b0;
        do @(negedge i_clk); while (board.pending.size() != 0);
        for (int i = 0; i < 16; i++) send_cmd(OP_REM, used_ids.size() == 0 ?
            16'h0300 + 16'(i) : 16'h0300 + 16'(i), 0, 0, 0);
        send_cmd(OP_REM, 16'h0000, 0, 0, 0);
        send_cmd(OP_REM, 16'hFFFF, 0, 0, 0);
        send_cmd(OP_REM, 16'h0101, 0, 0, 0);
        // random: mostly add/fire with a moving clock and reused ids
        clock_now = $urandom_range(0, 1000);
        for (k = 0; k < 360; k++) begin
            p = $urandom_range(0, 99);
            if (k == 180) begin
                cmd_if.valid <= 1'b0;
                do @(negedge i_clk); while (board.pending.size() != 0);
            end
            if (p < 40) begin
                id = 16'($urandom_range(0, 24));
                if ($urandom_range(0, 9) == 0) id = 16'($urandom());
                used_ids = {used_ids, id};
                if ($urandom_range(0, 9) == 0)
                    send_cmd(OP_ADD, id, rand64(), $urandom_range(0, 3) == 0 ? 32'd0 :
                             $urandom(), rand64());
                else
                    send_cmd(OP_ADD, id, clock_now + $urandom_range(0, 50),
                             $urandom_range(0, 9) == 0 ? 32'd0 : $urandom_range(1, 40),
                             rand64());
            end else if (p < 60) begin
                send_cmd(OP_REM, pick_id(), rand64(), $urandom(), rand64());
            end else if (p < 97) begin
                clock_now = clock_now + $urandom_range(0, 60);
                if ($urandom_range(0, 19) == 0) send_cmd(OP_FIRE, pick_id(), rand64(),
                                                         $urandom(), rand64());
                else send_cmd(OP_FIRE, pick_id(), rand64(), $urandom(), clock_now);
            end else begin
                send_cmd(OP_NOP, pick_id(), rand64(), $urandom(), rand64());
            end
        end
        cmd_if.valid <= 1'b0;
        stim_done = 1;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("covered add/remove/fire/unused commands: %0d results, %0d timer firings",
                 board.results_seen, board.fires_seen);
        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
